// ===== rtl/kvt_pkg.sv =====
// kvt_pkg: command codes, microcode word layout and control ROM for key_value_table.
// Used by kvt_seq and key_value_table; no dependencies.
`default_nettype none

package kvt_pkg;

  // Request commands; code 3 is a no-op
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // Jump conditions: step advances to its target when the condition holds
  localparam logic [1:0] COND_ALWAYS    = 2'd0;
  localparam logic [1:0] COND_IN_VALID  = 2'd1;
  localparam logic [1:0] COND_SCAN_LAST = 2'd2;
  localparam logic [1:0] COND_OUT_FREE  = 2'd3;

  localparam int STEP_W = 3;

  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DRAIN  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_VREAD  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_COMMIT = 3'd4;

  // Datapath strobes from one control word
  typedef struct packed {
    logic accept;   // take an input beat, clear scan state
    logic scan;     // read key memory at scan index, advance index
    logic vread;    // read value memory at matched slot
    logic commit;   // update table and load the result register
  } ctl_t;

  // Status bits sampled by the jump logic
  typedef struct packed {
    logic in_valid;
    logic scan_last;
    logic out_free;
  } stat_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '0;
    unique case (step)
      STEP_IDLE: begin
        w.ctl.accept = 1'b1;
        w.cond       = COND_IN_VALID;
        w.target     = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.ctl.scan = 1'b1;
        w.cond     = COND_SCAN_LAST;
        w.target   = STEP_DRAIN;
      end
      STEP_DRAIN: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_VREAD;
      end
      STEP_VREAD: begin
        w.ctl.vread = 1'b1;
        w.cond      = COND_ALWAYS;
        w.target    = STEP_COMMIT;
      end
      STEP_COMMIT: begin
        w.ctl.commit = 1'b1;
        w.cond       = COND_OUT_FREE;
        w.target     = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kvt_seq.sv =====
// kvt_seq: step counter and control ROM lookup with conditional jumps.
// Depends on kvt_pkg.
`default_nettype none

module kvt_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire kvt_pkg::stat_t stat,
  output kvt_pkg::ctl_t      ctl
);
  import kvt_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  uword_t            uw;
  logic              cond_ok;

  assign uw  = ucode_rom(step_r);
  assign ctl = uw.ctl;

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:    cond_ok = 1'b1;
      COND_IN_VALID:  cond_ok = stat.in_valid;
      COND_SCAN_LAST: cond_ok = stat.scan_last;
      COND_OUT_FREE:  cond_ok = stat.out_free;
      default:        cond_ok = 1'b1;
    endcase
    step_nxt = cond_ok ? uw.target : step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/key_value_table.sv =====
// key_value_table: bounded associative key/value store, microcoded scan.
// Depends on kvt_pkg and kvt_seq.
//
//   channel | direction | handshake           | beat payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | input     | in_valid/in_ready   | in_cmd, in_req_key, in_req_value
//   out     | output    | out_valid/out_ready | out_hit, out_read_value, out_refused,
//           |           |                     | out_entry_count
//
// Per request: the key memory has one read port, so the scan reads one slot per cycle; then
// the drain step empties the compare stage, the vread step reads the value memory and the
// commit step loads the result. Beats are taken only in the idle step, so a new beat waits
// until the last request has committed. Valid bits are cleared at reset, no clearing pass.
// in_ready is high only in the idle step; a held result does not block the next
// accept. A stalled output stretches the commit step until the result register frees.
`default_nettype none

module key_value_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic signed [31:0] in_req_key,
  input  wire logic signed [31:0] in_req_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_hit,
  output logic signed [31:0]      out_read_value,
  output logic                    out_refused,
  output logic [4:0]              out_entry_count
);
  import kvt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ctl_t  ctl;
  stat_t stat;

  // request latched at accept
  logic [1:0]         cmd_r;
  logic signed [31:0] key_r;
  logic signed [31:0] val_r;

  // table storage
  logic signed [31:0]     key_mem [TABLE_DEPTH];
  logic signed [31:0]     value_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CW-1:0]          count_r, count_nxt;

  // scan pipeline: read stage then compare stage
  logic [IW-1:0]      idx_r;
  logic signed [31:0] key_rd_r;
  logic [IW-1:0]      cmp_idx_r;
  logic               cmp_en_r;
  logic               vld_s_r;
  logic               match;

  logic               found_r;
  logic [IW-1:0]      slot_r;
  logic               free_found_r;
  logic [IW-1:0]      free_r;
  logic signed [31:0] val_rd_r;

  // write port
  logic          wr_val_en, wr_key_en;
  logic [IW-1:0] wr_addr;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic signed [31:0] out_read_value_r, out_read_value_nxt;
  logic               out_refused_r, out_refused_nxt;
  logic [4:0]         out_entry_count_r, out_entry_count_nxt;

  logic do_accept, do_commit, out_free;

  kvt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  assign out_free       = !out_valid_r || out_ready;
  assign stat.in_valid  = in_valid;
  assign stat.scan_last = (idx_r == IW'(TABLE_DEPTH - 1));
  assign stat.out_free  = out_free;

  assign in_ready  = ctl.accept;
  assign do_accept = ctl.accept && in_valid;
  assign do_commit = ctl.commit && out_free;

  assign match = cmp_en_r && vld_s_r && (key_rd_r == key_r);

  // scan control, match tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      cmp_en_r     <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      cmp_en_r <= ctl.scan;
      if (do_accept) begin
        idx_r        <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (ctl.scan) begin
          idx_r <= idx_r + IW'(1);
        end
        // lowest index wins for both the match and the free slot
        if (match && !found_r) begin
          found_r <= 1'b1;
        end
        if (cmp_en_r && !vld_s_r && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (do_accept) begin
      cmd_r <= in_cmd;
      key_r <= in_req_key;
      val_r <= in_req_value;
    end
    if (ctl.scan) begin
      cmp_idx_r <= idx_r;
      vld_s_r   <= valid_r[idx_r];
    end
    if (match && !found_r) begin
      slot_r <= cmp_idx_r;
    end
    if (cmp_en_r && !vld_s_r && !free_found_r) begin
      free_r <= cmp_idx_r;
    end
  end

  // key/value memories: one write port, registered reads
  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= key_r;
    end
    if (wr_val_en) begin
      value_mem[wr_addr] <= val_r;
    end
    if (ctl.scan) begin
      key_rd_r <= key_mem[idx_r];
    end
    if (ctl.vread) begin
      val_rd_r <= value_mem[slot_r];
    end
  end

  // commit: table update and result
  always_comb begin
    valid_nxt           = valid_r;
    count_nxt           = count_r;
    wr_val_en           = 1'b0;
    wr_key_en           = 1'b0;
    wr_addr             = slot_r;
    out_hit_nxt         = 1'b0;
    out_read_value_nxt  = '0;
    out_refused_nxt     = 1'b0;
    out_valid_nxt       = out_valid_r && !out_ready;

    if (do_commit) begin
      out_valid_nxt = 1'b1;
      case (cmd_r)
        CMD_INSERT: begin
          if (found_r) begin
            // present key: overwrite value only
            out_hit_nxt = 1'b1;
            wr_val_en   = 1'b1;
          end else if (free_found_r) begin
            wr_addr            = free_r;
            wr_val_en          = 1'b1;
            wr_key_en          = 1'b1;
            valid_nxt[free_r]  = 1'b1;
            count_nxt          = count_r + CW'(1);
          end else begin
            out_refused_nxt = 1'b1;
          end
        end
        CMD_SEARCH: begin
          if (found_r) begin
            out_hit_nxt        = 1'b1;
            out_read_value_nxt = val_rd_r;
          end
        end
        CMD_DELETE: begin
          if (found_r) begin
            out_hit_nxt        = 1'b1;
            out_read_value_nxt = val_rd_r;
            valid_nxt[slot_r]  = 1'b0;
            count_nxt          = count_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
    // entry count field wraps modulo 32
    out_entry_count_nxt = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_commit) begin
      out_hit_r         <= out_hit_nxt;
      out_read_value_r  <= out_read_value_nxt;
      out_refused_r     <= out_refused_nxt;
      out_entry_count_r <= out_entry_count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_refused     = out_refused_r;
  assign out_entry_count = out_entry_count_r;

  // count tracks the valid bits exactly
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == count_r)
    else $error("entry count out of step with valid bits");

  // a result only appears from the commit step
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.commit))
    else $error("result loaded outside commit");

  // a refused insert means every slot was in use
  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_refused_r) |-> (count_r == CW'(TABLE_DEPTH)))
    else $error("insert refused with free slots");

  // no accept while a request is in flight
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.scan || ctl.vread || ctl.commit) |-> !in_ready)
    else $error("input ready during request processing");

endmodule

`default_nettype wire
